[rtl/vlmv_pkg.sv]
// Shared types and constants of the vertex label majority vote block.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package vlmv_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_VERTICES_DEF = 4096;
    localparam int LABEL_COUNT_DEF  = 8;
    localparam int COUNT_WIDTH_DEF  = 16;

    // Fixed field widths of the ports.
    localparam int VERTEX_W = 12;
    localparam int LABEL_W  = 3;
    localparam int CORNERS  = 3;

    // Depth of the queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 2;

    // Item kinds.
    localparam logic KIND_VOTE  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Hand labels cast no vote.
    localparam logic [LABEL_W-1:0] LEFT_HAND_LABEL  = 3'd6;
    localparam logic [LABEL_W-1:0] RIGHT_HAND_LABEL = 3'd7;

    // One classified operation as it travels through the queue.
    typedef struct packed {
        logic                               is_query;
        logic [CORNERS-1:0][VERTEX_W-1:0]   vtx;
        logic [CORNERS-1:0]                 corner_ok;
        logic [LABEL_W-1:0]                 label;
    } op_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_VOTE,
        BS_QWAIT,
        BS_SCAN
    } back_state_t;

    function automatic logic is_hand_label(input logic [LABEL_W-1:0] label);
        return (label == LEFT_HAND_LABEL) || (label == RIGHT_HAND_LABEL);
    endfunction

endpackage

`default_nettype wire

[rtl/vlmv_front.sv]
// Front end: accepts items, drops hand-label votes and range-checks the corners.
// Depends on vlmv_pkg.
`default_nettype none

module vlmv_front #(
    parameter int MAX_VERTICES = vlmv_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic                          kind,
    input  wire logic [vlmv_pkg::VERTEX_W-1:0] vtx_a,
    input  wire logic [vlmv_pkg::VERTEX_W-1:0] vtx_b,
    input  wire logic [vlmv_pkg::VERTEX_W-1:0] vtx_c,
    input  wire logic [vlmv_pkg::LABEL_W-1:0]  tri_label,
    output logic                               push,
    output vlmv_pkg::op_t                      op
);

    logic accept;

    always_comb
    begin
        accept = start && !busy;
        // A vote with a hand label changes nothing, so it never enters the queue.
        push = accept && !((kind == vlmv_pkg::KIND_VOTE) && vlmv_pkg::is_hand_label(tri_label));

        op.is_query = (kind == vlmv_pkg::KIND_QUERY);
        op.vtx[0]   = vtx_a;
        op.vtx[1]   = vtx_b;
        op.vtx[2]   = vtx_c;
        op.label    = tri_label;
        op.corner_ok[0] = 32'(vtx_a) < 32'(MAX_VERTICES);
        op.corner_ok[1] = 32'(vtx_b) < 32'(MAX_VERTICES);
        op.corner_ok[2] = 32'(vtx_c) < 32'(MAX_VERTICES);
    end

endmodule

`default_nettype wire

[rtl/vlmv_queue.sv]
// Short operation queue between the front end and the back end.
// Depends on vlmv_pkg for the operation type and the depth.
`default_nettype none

module vlmv_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire vlmv_pkg::op_t push_op,
    input  wire logic          pop,
    output vlmv_pkg::op_t      head,
    output logic               empty,
    output logic               full
);

    localparam int DEPTH = vlmv_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vlmv_pkg::op_t    entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == CNT_W'(0));
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_op;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

endmodule

`default_nettype wire

[rtl/vlmv_store.sv]
// Vote counter store: one memory bank per label plus the clearing pass after reset.
// Depends on vlmv_pkg for the parameter defaults.
`default_nettype none

module vlmv_store #(
    parameter int MAX_VERTICES = vlmv_pkg::MAX_VERTICES_DEF,
    parameter int LABEL_COUNT  = vlmv_pkg::LABEL_COUNT_DEF,
    parameter int COUNT_WIDTH  = vlmv_pkg::COUNT_WIDTH_DEF,
    localparam int ADDR_W      = $clog2(MAX_VERTICES),
    localparam int BANK_W      = $clog2(LABEL_COUNT)
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   rd_en,
    input  wire logic [ADDR_W-1:0]                      rd_addr,
    output logic [LABEL_COUNT-1:0][COUNT_WIDTH-1:0]     rd_data,
    input  wire logic                                   wr_en,
    input  wire logic [BANK_W-1:0]                      wr_bank,
    input  wire logic [ADDR_W-1:0]                      wr_addr,
    input  wire logic [COUNT_WIDTH-1:0]                 wr_data,
    output logic                                        clearing
);

    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0] waddr;
    logic [COUNT_WIDTH-1:0] wdata;

    assign clearing = clearing_reg;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(MAX_VERTICES - 1))
            begin
                clearing_next = 1'b0;
            end
        end
        waddr = clearing_reg ? clr_addr_reg : wr_addr;
        wdata = clearing_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    for (genvar b = 0; b < LABEL_COUNT; b++)
    begin : g_bank
        logic [COUNT_WIDTH-1:0] mem [MAX_VERTICES];
        logic                   we;

        assign we = clearing_reg || (wr_en && (wr_bank == BANK_W'(b)));

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                mem[waddr] <= wdata;
            end
            if (rd_en)
            begin
                rd_data[b] <= mem[rd_addr];
            end
        end
    end

    a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !clearing_reg)
        else $error("counter write during the clearing pass");

endmodule

`default_nettype wire

[rtl/vlmv_back.sv]
// Back end: read-modify-write of the vote counters and the label search of a query.
// Depends on vlmv_pkg; drives the ports of vlmv_store.
`default_nettype none

module vlmv_back #(
    parameter int MAX_VERTICES = vlmv_pkg::MAX_VERTICES_DEF,
    parameter int LABEL_COUNT  = vlmv_pkg::LABEL_COUNT_DEF,
    parameter int COUNT_WIDTH  = vlmv_pkg::COUNT_WIDTH_DEF,
    localparam int ADDR_W      = $clog2(MAX_VERTICES),
    localparam int BANK_W      = $clog2(LABEL_COUNT)
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire vlmv_pkg::op_t                          q_head,
    input  wire logic                                   q_empty,
    output logic                                        pop,
    output logic                                        rd_en,
    output logic [ADDR_W-1:0]                           rd_addr,
    input  wire logic [LABEL_COUNT-1:0][COUNT_WIDTH-1:0] rd_data,
    output logic                                        wr_en,
    output logic [BANK_W-1:0]                           wr_bank,
    output logic [ADDR_W-1:0]                           wr_addr,
    output logic [COUNT_WIDTH-1:0]                      wr_data,
    output logic                                        done,
    output logic [vlmv_pkg::VERTEX_W-1:0]               result_vtx,
    output logic [vlmv_pkg::LABEL_W-1:0]                winning_label,
    output logic                                        label_valid
);

    vlmv_pkg::back_state_t state_reg, state_next;
    vlmv_pkg::op_t         op_reg, op_next;
    logic [1:0]            corner_reg, corner_next;

    // Write stage of the counter update and the write it made in the previous cycle.
    logic                   w_valid_reg, w_valid_next;
    logic [ADDR_W-1:0]      w_addr_reg, w_addr_next;
    logic [BANK_W-1:0]      w_bank_reg, w_bank_next;
    logic                   lw_valid_reg, lw_valid_next;
    logic [ADDR_W-1:0]      lw_addr_reg;
    logic [BANK_W-1:0]      lw_bank_reg;
    logic [COUNT_WIDTH-1:0] lw_data_reg;
    logic [COUNT_WIDTH-1:0] old_count;

    // Label search of a query.
    logic [BANK_W-1:0]      lbl_reg, lbl_next;
    logic [BANK_W-1:0]      best_lbl_reg, best_lbl_next;
    logic [COUNT_WIDTH-1:0] best_cnt_reg, best_cnt_next;
    logic [COUNT_WIDTH-1:0] scan_cnt;
    logic                   scan_better;
    logic [BANK_W-1:0]      cand_lbl;
    logic [COUNT_WIDTH-1:0] cand_cnt;
    logic                   found;

    logic                            done_reg, done_next;
    logic [vlmv_pkg::VERTEX_W-1:0]   result_vtx_reg, result_vtx_next;
    logic [vlmv_pkg::LABEL_W-1:0]    winning_label_reg, winning_label_next;
    logic                            label_valid_reg, label_valid_next;

    assign done          = done_reg;
    assign result_vtx    = result_vtx_reg;
    assign winning_label = winning_label_reg;
    assign label_valid   = label_valid_reg;

    // Counter update: the write of the previous corner is not yet in the read data.
    always_comb
    begin
        if (lw_valid_reg && (lw_addr_reg == w_addr_reg) && (lw_bank_reg == w_bank_reg))
        begin
            old_count = lw_data_reg;
        end
        else
        begin
            old_count = rd_data[w_bank_reg];
        end
        wr_en   = w_valid_reg;
        wr_bank = w_bank_reg;
        wr_addr = w_addr_reg;
        wr_data = (&old_count) ? old_count : old_count + COUNT_WIDTH'(1);
        lw_valid_next = w_valid_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        corner_next  = corner_reg;
        pop          = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = ADDR_W'(op_reg.vtx[corner_reg]);
        w_valid_next = 1'b0;
        w_addr_next  = ADDR_W'(op_reg.vtx[corner_reg]);
        w_bank_next  = BANK_W'(op_reg.label);
        lbl_next      = lbl_reg;
        best_lbl_next = best_lbl_reg;
        best_cnt_next = best_cnt_reg;
        done_next          = 1'b0;
        result_vtx_next    = result_vtx_reg;
        winning_label_next = winning_label_reg;
        label_valid_next   = label_valid_reg;

        scan_cnt    = rd_data[lbl_reg];
        scan_better = scan_cnt > best_cnt_reg;
        cand_lbl    = scan_better ? lbl_reg : best_lbl_reg;
        cand_cnt    = scan_better ? scan_cnt : best_cnt_reg;
        found       = op_reg.corner_ok[0] && (cand_cnt != '0);

        unique case (state_reg)
            vlmv_pkg::BS_IDLE:
            begin
                if (!q_empty)
                begin
                    pop         = 1'b1;
                    op_next     = q_head;
                    corner_next = '0;
                    state_next  = q_head.is_query ? vlmv_pkg::BS_QWAIT : vlmv_pkg::BS_VOTE;
                end
            end
            vlmv_pkg::BS_VOTE:
            begin
                rd_en        = 1'b1;
                w_valid_next = op_reg.corner_ok[corner_reg];
                if (corner_reg == 2'd2)
                begin
                    corner_next = '0;
                    if (!q_empty)
                    begin
                        pop        = 1'b1;
                        op_next    = q_head;
                        state_next = q_head.is_query ? vlmv_pkg::BS_QWAIT : vlmv_pkg::BS_VOTE;
                    end
                    else
                    begin
                        state_next = vlmv_pkg::BS_IDLE;
                    end
                end
                else
                begin
                    corner_next = corner_reg + 2'd1;
                end
            end
            vlmv_pkg::BS_QWAIT:
            begin
                rd_addr = ADDR_W'(op_reg.vtx[0]);
                // Wait out a pending counter write so that the read sees it.
                if (!w_valid_reg)
                begin
                    rd_en         = 1'b1;
                    lbl_next      = '0;
                    best_lbl_next = '0;
                    best_cnt_next = '0;
                    state_next    = vlmv_pkg::BS_SCAN;
                end
            end
            vlmv_pkg::BS_SCAN:
            begin
                best_lbl_next = cand_lbl;
                best_cnt_next = cand_cnt;
                if (lbl_reg == BANK_W'(LABEL_COUNT - 1))
                begin
                    done_next          = 1'b1;
                    result_vtx_next    = op_reg.vtx[0];
                    label_valid_next   = found;
                    winning_label_next = found ? cand_lbl[vlmv_pkg::LABEL_W-1:0] : '0;
                    state_next         = vlmv_pkg::BS_IDLE;
                end
                else
                begin
                    lbl_next = lbl_reg + BANK_W'(1);
                end
            end
            default:
            begin
                state_next = vlmv_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= vlmv_pkg::BS_IDLE;
            corner_reg   <= '0;
            w_valid_reg  <= 1'b0;
            lw_valid_reg <= 1'b0;
            lbl_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            corner_reg   <= corner_next;
            w_valid_reg  <= w_valid_next;
            lw_valid_reg <= lw_valid_next;
            lbl_reg      <= lbl_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        w_addr_reg        <= w_addr_next;
        w_bank_reg        <= w_bank_next;
        lw_addr_reg       <= w_addr_reg;
        lw_bank_reg       <= w_bank_reg;
        lw_data_reg       <= wr_data;
        best_lbl_reg      <= best_lbl_next;
        best_cnt_reg      <= best_cnt_next;
        result_vtx_reg    <= result_vtx_next;
        winning_label_reg <= winning_label_next;
        label_valid_reg   <= label_valid_next;
    end

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == vlmv_pkg::BS_SCAN)
        else $error("result strobe without a finished label search");

    a_write_follows_vote_read: assert property (@(posedge clk) disable iff (!rst_n)
        w_valid_reg |-> $past(state_reg) == vlmv_pkg::BS_VOTE)
        else $error("counter write without a vote read one cycle before");

    a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == vlmv_pkg::BS_SCAN |-> !wr_en)
        else $error("counter write while a query reads the banks");

endmodule

`default_nettype wire

[rtl/vertex_label_majority_vote.sv]
// Top level of the vertex label majority vote block.
// Depends on vlmv_pkg, vlmv_front, vlmv_queue, vlmv_store and vlmv_back.
//
//  Channel   Handshake            Payload
//  --------  -------------------  ----------------------------------------------
//  input     start / busy         kind, vtx_a, vtx_b, vtx_c, tri_label
//  result    done (one cycle)     result_vtx, winning_label, label_valid
//
// A transfer on the input takes place at a rising edge with start high and busy low.
// A result appears on the result ports in the cycle in which done is high and stays
// there until the next result. After reset the counter banks are cleared, one vertex
// row per cycle, which holds busy high until the last row is cleared.
// A triangle vote makes one read of its label bank per corner in the back end;
// each counter write overlaps the next read. A hand-label vote takes no back-end time.
// A query waits while a counter write of the vote before it is still pending, then
// makes one bank read and compares one label per cycle; done rises after the last label.
// The two-entry queue lets the front accept items while the back end works; busy is
// high only while the queue is full or the banks are being cleared.
`default_nettype none

module vertex_label_majority_vote #(
    parameter int MAX_VERTICES = vlmv_pkg::MAX_VERTICES_DEF,
    parameter int LABEL_COUNT  = vlmv_pkg::LABEL_COUNT_DEF,
    parameter int COUNT_WIDTH  = vlmv_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          kind,
    input  wire logic [vlmv_pkg::VERTEX_W-1:0] vtx_a,
    input  wire logic [vlmv_pkg::VERTEX_W-1:0] vtx_b,
    input  wire logic [vlmv_pkg::VERTEX_W-1:0] vtx_c,
    input  wire logic [vlmv_pkg::LABEL_W-1:0]  tri_label,
    output logic                               done,
    output logic [vlmv_pkg::VERTEX_W-1:0]      result_vtx,
    output logic [vlmv_pkg::LABEL_W-1:0]       winning_label,
    output logic                               label_valid
);

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int BANK_W = $clog2(LABEL_COUNT);

    // Front end to queue.
    logic          push;
    vlmv_pkg::op_t push_op;

    // Queue to back end.
    vlmv_pkg::op_t q_head;
    logic          q_empty;
    logic          q_full;
    logic          pop;

    // Back end to counter store.
    logic                                   rd_en;
    logic [ADDR_W-1:0]                      rd_addr;
    logic [LABEL_COUNT-1:0][COUNT_WIDTH-1:0] rd_data;
    logic                                   wr_en;
    logic [BANK_W-1:0]                      wr_bank;
    logic [ADDR_W-1:0]                      wr_addr;
    logic [COUNT_WIDTH-1:0]                 wr_data;
    logic                                   clearing;

    // The input is held off while the queue has no room or the banks are being cleared.
    assign busy = q_full || clearing;

    vlmv_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .vtx_a     (vtx_a),
        .vtx_b     (vtx_b),
        .vtx_c     (vtx_c),
        .tri_label (tri_label),
        .push      (push),
        .op        (push_op)
    );

    vlmv_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (q_head),
        .empty   (q_empty),
        .full    (q_full)
    );

    vlmv_store #(
        .MAX_VERTICES (MAX_VERTICES),
        .LABEL_COUNT  (LABEL_COUNT),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_bank  (wr_bank),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .clearing (clearing)
    );

    vlmv_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .LABEL_COUNT  (LABEL_COUNT),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_head        (q_head),
        .q_empty       (q_empty),
        .pop           (pop),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_bank       (wr_bank),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .done          (done),
        .result_vtx    (result_vtx),
        .winning_label (winning_label),
        .label_valid   (label_valid)
    );

endmodule

`default_nettype wire
